@@ design/tiba_pkg.sv @@
package tiba_pkg;

    typedef enum logic [4:0] {
        OP_CONST0       = 5'd0,
        OP_CONST1       = 5'd1,
        OP_CONST2       = 5'd2,
        OP_CONST3       = 5'd3,
        OP_CONSTINT     = 5'd4,
        OP_PUSHCONST0   = 5'd5,
        OP_PUSHCONST1   = 5'd6,
        OP_PUSHCONST2   = 5'd7,
        OP_PUSHCONST3   = 5'd8,
        OP_PUSHCONSTINT = 5'd9,
        OP_NEG          = 5'd10,
        OP_ADD          = 5'd11,
        OP_SUB          = 5'd12,
        OP_MUL          = 5'd13,
        OP_DIV          = 5'd14,
        OP_MOD          = 5'd15,
        OP_AND          = 5'd16,
        OP_OR           = 5'd17,
        OP_XOR          = 5'd18,
        OP_LSL          = 5'd19,
        OP_LSR          = 5'd20,
        OP_ASR          = 5'd21,
        OP_LT           = 5'd22,
        OP_LE           = 5'd23,
        OP_GT           = 5'd24,
        OP_GE           = 5'd25,
        OP_ULT          = 5'd26,
        OP_UGE          = 5'd27,
        OP_OFFSETINT    = 5'd28,
        OP_ISINT        = 5'd29
    } tiba_op_t;

    localparam logic [1:0] STEP_ONE = 2'd1;
    localparam logic [1:0] STEP_TWO = 2'd2;

    typedef struct packed {
        logic       push;
        logic       pop;
        logic [1:0] step;
        logic       dz;
    } tiba_ctl_t;

endpackage

@@ design/tiba_if.sv @@
interface tiba_in_if;
    logic               valid;
    logic               ready;
    logic [4:0]         func;
    logic [63:0]        acc_in;
    logic [63:0]        stack_top;
    logic signed [31:0] immediate;

    modport source (output valid, func, acc_in, stack_top, immediate, input ready);
    modport sink (input valid, func, acc_in, stack_top, immediate, output ready);
endinterface

interface tiba_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] acc_out;
    logic        push_acc;
    logic        pop_top;
    logic [1:0]  pc_step;
    logic        div_zero;

    modport source (output valid, acc_out, push_acc, pop_top, pc_step, div_zero, input ready);
    modport sink (input valid, acc_out, push_acc, pop_top, pc_step, div_zero, output ready);
endinterface

@@ design/tiba_div_pipe.sv @@
module tiba_div_pipe #(
    parameter int VB    = 63,
    parameter int TAG_W = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  logic [VB-1:0]    dividend,
    input  logic [VB-1:0]    divisor,
    input  logic [TAG_W-1:0] tag_in,
    output logic             out_valid,
    output logic [VB-1:0]    quo,
    output logic [VB-1:0]    rem,
    output logic [TAG_W-1:0] tag_out
);

    logic             v_reg   [VB];
    logic [VB-1:0]    d_reg   [VB];
    logic [VB-1:0]    ds_reg  [VB];
    logic [VB-1:0]    r_reg   [VB];
    logic [TAG_W-1:0] tag_reg [VB];

    for (genvar k = 0; k < VB; k++) begin : g_stage
        logic             v_cur;
        logic [VB-1:0]    d_cur;
        logic [VB-1:0]    ds_cur;
        logic [VB-1:0]    r_cur;
        logic [TAG_W-1:0] tag_cur;
        logic [VB:0]      trial;
        logic [VB:0]      diff;
        logic             ge;

        if (k == 0) begin : g_first
            assign v_cur   = in_valid;
            assign d_cur   = dividend;
            assign ds_cur  = divisor;
            assign r_cur   = '0;
            assign tag_cur = tag_in;
        end else begin : g_next
            assign v_cur   = v_reg[k-1];
            assign d_cur   = d_reg[k-1];
            assign ds_cur  = ds_reg[k-1];
            assign r_cur   = r_reg[k-1];
            assign tag_cur = tag_reg[k-1];
        end

        assign trial = {r_cur, d_cur[VB-1]};
        assign ge    = trial >= {1'b0, ds_cur};
        assign diff  = trial - {1'b0, ds_cur};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[k] <= v_cur;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                d_reg[k]   <= {d_cur[VB-2:0], ge};
                ds_reg[k]  <= ds_cur;
                r_reg[k]   <= ge ? diff[VB-1:0] : trial[VB-1:0];
                tag_reg[k] <= tag_cur;
            end
        end
    end

    assign out_valid = v_reg[VB-1];
    assign quo       = d_reg[VB-1];
    assign rem       = r_reg[VB-1];
    assign tag_out   = tag_reg[VB-1];

endmodule

@@ design/tagged_integer_bytecode_alu.sv @@
// Channel  Role    Payload
// cmd      sink    func, acc_in, stack_top, immediate
// rsp      source  acc_out, push_acc, pop_top, pc_step, div_zero
//
// One transaction is accepted every cycle while rsp is not stalled.
// The divider resolves one quotient bit per stage.
// Reset clears only the stage valid bits.
// When rsp stalls with a result waiting, the whole pipeline holds and cmd.ready drops.
module tagged_integer_bytecode_alu
    import tiba_pkg::*;
#(
    parameter int WORD_BITS = 64
) (
    input logic       clk,
    input logic       rst_n,
    tiba_in_if.sink   cmd,
    tiba_out_if.source rsp
);

    localparam int W = WORD_BITS;
    localparam int V = WORD_BITS - 1;

    typedef struct packed {
        tiba_ctl_t    ctl;
        logic         is_div;
        logic         is_mod;
        logic         neg_q;
        logic         neg_r;
        logic [W-1:0] res;
    } side_t;

    localparam int TAG_W = $bits(side_t);

    function automatic logic [W-1:0] enc(input logic [V-1:0] v);
        enc = {v, 1'b1};
    endfunction

    logic en;

    logic [W-1:0]        accw;
    logic signed [V-1:0] n_s;
    logic signed [V-1:0] m_s;
    logic signed [63:0]  imm64;
    logic [V-1:0]        imm_v;
    logic [5:0]          cnt;
    logic [4:0]          kidx;
    side_t               side_next;

    logic                v1_reg;
    side_t               side1_reg;
    logic [V-1:0]        n1_reg;
    logic [V-1:0]        m1_reg;
    logic                mul1_reg;

    logic                v2_reg;
    side_t               side2_reg;
    logic [V-1:0]        an2_reg;
    logic [V-1:0]        am2_reg;
    logic                mul2_reg;
    logic [63:0]         pp0_reg;
    logic [31:0]         pp1_reg;
    logic [31:0]         pp2_reg;

    logic [63:0]         a64;
    logic [63:0]         b64;
    logic [63:0]         prod;

    logic                v3_reg;
    side_t               side3_reg;
    side_t               side3_next;
    logic [V-1:0]        an3_reg;
    logic [V-1:0]        am3_reg;

    logic                dv_valid;
    logic [V-1:0]        dv_quo;
    logic [V-1:0]        dv_rem;
    logic [TAG_W-1:0]    dv_tag;
    side_t               dv_side;

    logic                vo_reg;
    logic [W-1:0]        res_reg;
    tiba_ctl_t           ctl_reg;
    logic [W-1:0]        res_next;

    assign en        = !vo_reg || rsp.ready;
    assign cmd.ready = en;

    assign accw  = cmd.acc_in[W-1:0];
    assign n_s   = signed'(accw[W-1:1]);
    assign m_s   = signed'(cmd.stack_top[W-1:1]);
    assign imm64 = 64'(cmd.immediate);
    assign imm_v = imm64[V-1:0];
    assign cnt   = m_s[5:0];
    assign kidx  = cmd.func - OP_PUSHCONST0;

    always_comb
    begin
        side_next          = '0;
        side_next.res      = accw;
        side_next.ctl.step = STEP_ONE;
        side_next.ctl.pop  = (cmd.func >= OP_ADD) && (cmd.func <= OP_UGE);
        side_next.neg_q    = n_s[V-1] ^ m_s[V-1];
        side_next.neg_r    = n_s[V-1];
        case (cmd.func)
            OP_CONST0, OP_CONST1, OP_CONST2, OP_CONST3:
                side_next.res = enc(V'(cmd.func));
            OP_CONSTINT:
            begin
                side_next.res      = enc(imm_v);
                side_next.ctl.step = STEP_TWO;
            end
            OP_PUSHCONST0, OP_PUSHCONST1, OP_PUSHCONST2, OP_PUSHCONST3:
            begin
                side_next.res      = enc(V'(kidx));
                side_next.ctl.push = 1'b1;
            end
            OP_PUSHCONSTINT:
            begin
                side_next.res      = enc(imm_v);
                side_next.ctl.push = 1'b1;
                side_next.ctl.step = STEP_TWO;
            end
            OP_NEG:        side_next.res = enc(V'(-n_s));
            OP_ADD:        side_next.res = enc(V'(n_s + m_s));
            OP_SUB:        side_next.res = enc(V'(n_s - m_s));
            OP_MUL:        side_next.res = accw;
            OP_DIV:
            begin
                side_next.is_div = 1'b1;
                side_next.ctl.dz = (m_s == '0);
            end
            OP_MOD:
            begin
                side_next.is_mod = 1'b1;
                side_next.ctl.dz = (m_s == '0);
            end
            OP_AND:        side_next.res = enc(V'(n_s & m_s));
            OP_OR:         side_next.res = enc(V'(n_s | m_s));
            OP_XOR:        side_next.res = enc(V'(n_s ^ m_s));
            OP_LSL:        side_next.res = enc(V'(n_s << cnt));
            OP_LSR:        side_next.res = enc(V'($unsigned(n_s) >> cnt));
            OP_ASR:        side_next.res = enc(V'(n_s >>> cnt));
            OP_LT:         side_next.res = enc(V'(n_s < m_s));
            OP_LE:         side_next.res = enc(V'(n_s <= m_s));
            OP_GT:         side_next.res = enc(V'(n_s > m_s));
            OP_GE:         side_next.res = enc(V'(n_s >= m_s));
            OP_ULT:        side_next.res = enc(V'($unsigned(n_s) < $unsigned(m_s)));
            OP_UGE:        side_next.res = enc(V'($unsigned(n_s) >= $unsigned(m_s)));
            OP_OFFSETINT:
            begin
                side_next.res      = enc(V'(n_s + signed'(imm_v)));
                side_next.ctl.step = STEP_TWO;
            end
            OP_ISINT:      side_next.res = enc(V'(accw[0]));
            default:       side_next.res = accw;
        endcase
    end

    assign a64  = 64'(n1_reg);
    assign b64  = 64'(m1_reg);
    assign prod = pp0_reg + {pp1_reg + pp2_reg, 32'd0};

    always_comb
    begin
        side3_next = side2_reg;
        if (mul2_reg)
        begin
            side3_next.res = enc(prod[V-1:0]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= cmd.valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            vo_reg <= dv_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side1_reg <= side_next;
            n1_reg    <= n_s;
            m1_reg    <= m_s;
            mul1_reg  <= (cmd.func == OP_MUL);

            side2_reg <= side1_reg;
            an2_reg   <= n1_reg[V-1] ? V'(-n1_reg) : n1_reg;
            am2_reg   <= m1_reg[V-1] ? V'(-m1_reg) : m1_reg;
            mul2_reg  <= mul1_reg;
            pp0_reg   <= a64[31:0] * b64[31:0];
            pp1_reg   <= a64[31:0] * b64[63:32];
            pp2_reg   <= a64[63:32] * b64[31:0];

            side3_reg <= side3_next;
            an3_reg   <= an2_reg;
            am3_reg   <= am2_reg;

            res_reg   <= res_next;
            ctl_reg   <= dv_side.ctl;
        end
    end

    tiba_div_pipe #(
        .VB    (V),
        .TAG_W (TAG_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v3_reg),
        .dividend  (an3_reg),
        .divisor   (am3_reg),
        .tag_in    (side3_reg),
        .out_valid (dv_valid),
        .quo       (dv_quo),
        .rem       (dv_rem),
        .tag_out   (dv_tag)
    );

    assign dv_side = side_t'(dv_tag);

    always_comb
    begin
        res_next = dv_side.res;
        if (dv_side.is_div && !dv_side.ctl.dz)
        begin
            res_next = enc(dv_side.neg_q ? V'(-dv_quo) : dv_quo);
        end
        else if (dv_side.is_mod && !dv_side.ctl.dz)
        begin
            res_next = enc(dv_side.neg_r ? V'(-dv_rem) : dv_rem);
        end
    end

    assign rsp.valid    = vo_reg;
    assign rsp.acc_out  = 64'(res_reg);
    assign rsp.push_acc = ctl_reg.push;
    assign rsp.pop_top  = ctl_reg.pop;
    assign rsp.pc_step  = ctl_reg.step;
    assign rsp.div_zero = ctl_reg.dz;

endmodule
